// ===== hw/rtl/ysa_pkg.sv =====
// constants, types and helpers for the yuv saturation adjust pipeline
`default_nettype none

package ysa_pkg;

    localparam int PIXEL_BITS = 12;
    localparam int GAIN_BITS  = 12;
    localparam int COEF_BITS  = 18;
    localparam int FRAC       = 14;
    localparam int GAIN_FRAC  = 8;
    localparam int OUT_SHIFT  = 2 * FRAC;

    localparam logic [GAIN_BITS-1:0] GAIN_RESET = GAIN_BITS'(256);

    // y, u, v at 14 fraction bits, signed
    localparam int Y_W   = PIXEL_BITS + 15;
    localparam int U_W   = PIXEL_BITS + 14;
    localparam int V_W   = PIXEL_BITS + 15;
    // chroma times gain, before and after the 8-bit rounding shift
    localparam int UP_W  = U_W + GAIN_BITS + 1;
    localparam int VP_W  = V_W + GAIN_BITS + 1;
    localparam int UG_W  = UP_W - GAIN_FRAC;
    localparam int VG_W  = VP_W - GAIN_FRAC;
    // back-conversion accumulator at 28 fraction bits
    localparam int ACC_W = COEF_BITS + VG_W;
    // forward matrix row sum
    localparam int SUM1_W = COEF_BITS + PIXEL_BITS + 3;

    localparam int TDATA_W = ((3 * PIXEL_BITS + 7) / 8) * 8;

    typedef logic signed [COEF_BITS-1:0] coef_t;
    typedef logic [PIXEL_BITS-1:0]       pixel_t;

    localparam coef_t K_YR = coef_t'(4899);
    localparam coef_t K_YG = coef_t'(9617);
    localparam coef_t K_YB = coef_t'(1868);
    localparam coef_t K_UR = coef_t'(-2408);
    localparam coef_t K_UG = coef_t'(-4735);
    localparam coef_t K_UB = coef_t'(7143);
    localparam coef_t K_VR = coef_t'(10076);
    localparam coef_t K_VG = coef_t'(-8438);
    localparam coef_t K_VB = coef_t'(-1638);
    localparam coef_t K_RV = coef_t'(18678);
    localparam coef_t K_GU = coef_t'(-6472);
    localparam coef_t K_GV = coef_t'(-9519);
    localparam coef_t K_BU = coef_t'(33292);

    localparam logic signed [UP_W-1:0]  UP_HALF  = UP_W'(1 << (GAIN_FRAC - 1));
    localparam logic signed [VP_W-1:0]  VP_HALF  = VP_W'(1 << (GAIN_FRAC - 1));
    localparam logic signed [ACC_W-1:0] ACC_HALF = ACC_W'(1) << (OUT_SHIFT - 1);

    // one row of the forward matrix, constant coefficients
    function automatic logic signed [SUM1_W-1:0] mat_row(
        input coef_t  ka,
        input coef_t  kb,
        input coef_t  kc,
        input pixel_t pa,
        input pixel_t pb,
        input pixel_t pc
    );
        logic signed [SUM1_W-1:0] acc;
        acc = ka * $signed({1'b0, pa}) + kb * $signed({1'b0, pb})
            + kc * $signed({1'b0, pc});
        return acc;
    endfunction

    // round to nearest (ties up) at 28 fraction bits, then saturate
    function automatic pixel_t round_sat(input logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W-1:0] t;
        pixel_t                  res;
        t = acc + ACC_HALF;
        if (t[ACC_W-1]) begin
            res = '0;
        end else if (|t[ACC_W-2:OUT_SHIFT+PIXEL_BITS]) begin
            res = '1;
        end else begin
            res = t[OUT_SHIFT+PIXEL_BITS-1:OUT_SHIFT];
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/yuv_saturation_adjust.sv =====
// throughput: one pixel per cycle while m_tready is high, four register stages with a valid bit each
// stages: forward matrix, chroma gain multiply, round and back-matrix products,
// final sum with round and saturate; a stage advances when it is empty or the next one moves
// reset (aresetn low, synchronous) empties the pipeline and sets chroma_gain to 1.0
`default_nettype none

module yuv_saturation_adjust import ysa_pkg::*; (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,

    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [GAIN_BITS-1:0] cfg_data,   // chroma_gain, unsigned q4.8

    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [TDATA_W-1:0]   s_tdata,    // red_in, green_in, blue_in, zero pad

    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [TDATA_W-1:0]        m_tdata     // red_out, green_out, blue_out, zero pad
);

    logic [GAIN_BITS-1:0] gain_reg;

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic en1, en2, en3, en4;

    // stage 1
    logic signed [Y_W-1:0] y1_reg;
    logic signed [U_W-1:0] u1_reg;
    logic signed [V_W-1:0] v1d_reg;
    logic signed [SUM1_W-1:0] y_next, u_next, v_next;
    pixel_t red_in, green_in, blue_in;

    // stage 2
    logic signed [Y_W-1:0]  y2_reg;
    logic signed [UP_W-1:0] up2_reg;
    logic signed [VP_W-1:0] vp2_reg;
    logic signed [UP_W-1:0] up_next;
    logic signed [VP_W-1:0] vp_next;

    // stage 3
    logic signed [ACC_W-1:0] ys3_reg, prv3_reg, pgu3_reg, pgv3_reg, pbu3_reg;
    logic signed [UP_W-1:0]  ur_next;
    logic signed [VP_W-1:0]  vr_next;
    logic signed [UG_W-1:0]  ug_next;
    logic signed [VG_W-1:0]  vg_next;
    logic signed [ACC_W-1:0] ys_next, prv_next, pgu_next, pgv_next, pbu_next;

    // stage 4
    pixel_t red_reg, green_reg, blue_reg;
    logic signed [ACC_W-1:0] racc_next, gacc_next, bacc_next;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            gain_reg <= GAIN_RESET;
        end else if (cfg_valid && cfg_ready) begin
            gain_reg <= cfg_data;
        end
    end

    // a stage takes new data when it is empty or its content moves on
    assign en4      = !v4_reg || m_tready;
    assign en3      = !v3_reg || en4;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign s_tready = en1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (en1) v1_reg <= s_tvalid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
        end
    end

    // stage 1: forward matrix
    assign red_in   = s_tdata[PIXEL_BITS-1:0];
    assign green_in = s_tdata[2*PIXEL_BITS-1:PIXEL_BITS];
    assign blue_in  = s_tdata[3*PIXEL_BITS-1:2*PIXEL_BITS];

    always_comb begin
        y_next = mat_row(K_YR, K_YG, K_YB, red_in, green_in, blue_in);
        u_next = mat_row(K_UR, K_UG, K_UB, red_in, green_in, blue_in);
        v_next = mat_row(K_VR, K_VG, K_VB, red_in, green_in, blue_in);
    end

    always_ff @(posedge aclk) begin
        if (en1) begin
            y1_reg  <= y_next[Y_W-1:0];
            u1_reg  <= u_next[U_W-1:0];
            v1d_reg <= v_next[V_W-1:0];
        end
    end

    // stage 2: chroma gain
    always_comb begin
        up_next = u1_reg * $signed({1'b0, gain_reg});
        vp_next = v1d_reg * $signed({1'b0, gain_reg});
    end

    always_ff @(posedge aclk) begin
        if (en2) begin
            y2_reg  <= y1_reg;
            up2_reg <= up_next;
            vp2_reg <= vp_next;
        end
    end

    // stage 3: round the gained chroma, back-matrix products
    always_comb begin
        ur_next  = up2_reg + UP_HALF;
        vr_next  = vp2_reg + VP_HALF;
        ug_next  = ur_next[UP_W-1:GAIN_FRAC];
        vg_next  = vr_next[VP_W-1:GAIN_FRAC];
        ys_next  = ACC_W'(y2_reg) <<< FRAC;
        prv_next = K_RV * vg_next;
        pgu_next = K_GU * ug_next;
        pgv_next = K_GV * vg_next;
        pbu_next = K_BU * ug_next;
    end

    always_ff @(posedge aclk) begin
        if (en3) begin
            ys3_reg  <= ys_next;
            prv3_reg <= prv_next;
            pgu3_reg <= pgu_next;
            pgv3_reg <= pgv_next;
            pbu3_reg <= pbu_next;
        end
    end

    // stage 4: sums, round and saturate
    always_comb begin
        racc_next = ys3_reg + prv3_reg;
        gacc_next = ys3_reg + pgu3_reg + pgv3_reg;
        bacc_next = ys3_reg + pbu3_reg;
    end

    always_ff @(posedge aclk) begin
        if (en4) begin
            red_reg   <= round_sat(racc_next);
            green_reg <= round_sat(gacc_next);
            blue_reg  <= round_sat(bacc_next);
        end
    end

    assign m_tvalid = v4_reg;
    assign m_tdata  = TDATA_W'({blue_reg, green_reg, red_reg});

endmodule

`default_nettype wire
